>>> hw/rtl/pdg_pkg.sv
// ----------------------------------------------------------------------------
// pdg_pkg: shared types and constants of the Poisson-disc grid checker
// Status codes, sequencer states, register indexes, register widths and
// reset values, and the control bundle for the distance unit.
// ----------------------------------------------------------------------------
package pdg_pkg;

   // register widths
   localparam int AREA_W      = 15;
   localparam int GAP_W       = 32;
   localparam int INV_W       = 24;
   localparam int GRID_COLS_W = 8;
   localparam int GRID_ROWS_W = 7;

   // register reset values
   localparam logic [AREA_W-1:0]      AREA_WIDTH_RST  = 15'd10240;
   localparam logic [AREA_W-1:0]      AREA_HEIGHT_RST = 15'd7680;
   localparam logic [GAP_W-1:0]       GAP_SQUARED_RST = 32'd36864;
   localparam logic [INV_W-1:0]       INV_SIDE_RST    = 24'd7723;
   localparam logic [GRID_COLS_W-1:0] GRID_COLS_RST   = 8'd75;
   localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RST   = 7'd56;

   // Q11.4 times Q8.16 gives Q.20; the integer part is the cell index
   localparam int FRAC_SHIFT = 20;

   // config port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // result fields
   localparam int STATUS_W     = 2;
   localparam int OUT_COL_W    = 7;
   localparam int OUT_ROW_W    = 6;
   localparam int RSP_TDATA_W  = 16;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ACCEPT        = 2'd0,
      STATUS_OUT_OF_BOUNDS = 2'd1,
      STATUS_CONFLICT      = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_AREA_WIDTH  = 3'd0,
      REG_AREA_HEIGHT = 3'd1,
      REG_GAP_SQUARED = 3'd2,
      REG_INV_SIDE    = 3'd3,
      REG_GRID_COLS   = 3'd4,
      REG_GRID_ROWS   = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCALE,
      ST_BOUND,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } pdg_state_type;

   // sequencer to distance unit
   typedef struct packed {
      logic clear;   // reset the conflict flag for a new candidate
      logic probe;   // a live neighbor read was issued this cycle
   } dist_ctrl_type;

endpackage

>>> hw/rtl/pdg_cell_mem.sv
// ----------------------------------------------------------------------------
// pdg_cell_mem: grid cell store
// Single write port, single read port, read data registered.
// Each word is a valid mark above the stored y and x coordinates.
// ----------------------------------------------------------------------------
module pdg_cell_mem #(
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = 13,
   parameter int DATA_W = 33
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pdg_dist_unit.sv
// ----------------------------------------------------------------------------
// pdg_dist_unit: neighbor distance check
// Three-stage pipe behind the cell store read: coordinate differences,
// squares, then sum and compare against the gap. Sticky conflict flag.
// ----------------------------------------------------------------------------
module pdg_dist_unit
   import pdg_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dist_ctrl_type                 ctrl,
   input  logic signed [COORD_WIDTH-1:0] cand_x,
   input  logic signed [COORD_WIDTH-1:0] cand_y,
   input  logic                          cell_valid,
   input  logic signed [COORD_WIDTH-1:0] cell_x,
   input  logic signed [COORD_WIDTH-1:0] cell_y,
   input  logic [GAP_W-1:0]              gap_squared,
   output logic                          conflict,
   output logic                          busy
);

   localparam int DW    = COORD_WIDTH + 1;
   localparam int SQ_W  = 2 * COORD_WIDTH + 1;
   localparam int SUM_W = SQ_W + 1;
   localparam int CMP_W = (SUM_W > GAP_W) ? SUM_W : GAP_W;

   logic                 rd_vld_ff, rd_vld_in;
   logic                 a_vld_ff, a_vld_in;
   logic                 b_vld_ff, b_vld_in;
   logic                 conflict_ff, conflict_in;
   logic signed [DW-1:0] dx_ff, dx_in;
   logic signed [DW-1:0] dy_ff, dy_in;
   logic [SQ_W-1:0]      sqx_ff, sqx_in;
   logic [SQ_W-1:0]      sqy_ff, sqy_in;
   logic signed [2*DW-1:0] prod_x, prod_y;
   logic [SUM_W-1:0]     dist_sum;
   logic                 near;

   always_comb begin
      // stage A: differences, only for an occupied cell
      rd_vld_in = ctrl.probe;
      a_vld_in  = rd_vld_ff & cell_valid;
      dx_in     = DW'(cand_x) - DW'(cell_x);
      dy_in     = DW'(cand_y) - DW'(cell_y);

      // stage B: squares
      b_vld_in = a_vld_ff;
      prod_x   = dx_ff * dx_ff;
      prod_y   = dy_ff * dy_ff;
      sqx_in   = prod_x[SQ_W-1:0];
      sqy_in   = prod_y[SQ_W-1:0];

      // stage C: strictly closer than the gap marks a conflict
      dist_sum = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
      near     = CMP_W'(dist_sum) < CMP_W'(gap_squared);
      if (ctrl.clear) begin
         conflict_in = 1'b0;
      end else begin
         conflict_in = conflict_ff | (b_vld_ff & near);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         a_vld_ff    <= 1'b0;
         b_vld_ff    <= 1'b0;
         conflict_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= rd_vld_in;
         a_vld_ff    <= a_vld_in;
         b_vld_ff    <= b_vld_in;
         conflict_ff <= conflict_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
   end

   assign conflict = conflict_ff;
   assign busy     = rd_vld_ff | a_vld_ff | b_vld_ff;

endmodule

>>> hw/rtl/poisson_disc_grid_check_insert_core.sv
// ----------------------------------------------------------------------------
// poisson_disc_grid_check_insert_core: grid check and insert for disc sampling
// Tests candidate points against a cell grid of stored points and stores
// those that keep the minimum spacing to every point in the 3x3 block.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  candidate stream; tdata carries cand_x and cand_y (signed Q11.4).
//   rsp_*  one result per candidate: status, cell column and cell row.
//   csr_*  register writes (index, data); always ready, take effect from the
//          next candidate. Write only while no candidate is in flight.
// Timing:
//   One candidate at a time. An in-bounds candidate passes from acceptance
//   to the next req_tready through scaling, bound check, reads of the nine
//   neighbor cells (those inside the grid) from the single-port-read cell
//   store, a drain of the distance pipe (shorter when the last neighbor reads
//   fall past the grid border), then the result and, if accepted, the
//   write-back. An out-of-bounds candidate goes from the bound check to the
//   result. The result shows on rsp_* in the same cycle that req_tready returns.
// Reset:
//   Registers return to their defaults and a clearing pass writes every cell
//   empty, one cell a cycle, MAX_COLUMNS*MAX_ROWS cells (8192 by default),
//   with req_tready low.
// Stall:
//   The result sits in an output register; the next candidate is accepted
//   and worked on while it waits, and is held at the end until it is taken.
// ----------------------------------------------------------------------------
module poisson_disc_grid_check_insert_core
   import pdg_pkg::*;
#(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 64,
   parameter int COORD_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // candidate stream
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // [COORD_WIDTH-1:0] cand_x, [2*COORD_WIDTH-1:COORD_WIDTH] cand_y, zero pad
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,
   // result stream
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // [1:0] status, [8:2] cell_column, [14:9] cell_row, [15] zero
   output logic [RSP_TDATA_W-1:0]                  rsp_tdata,
   // register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]                  csr_index,
   input  logic [CSR_DATA_W-1:0]                   csr_data
);

   localparam int CW         = COORD_WIDTH;
   localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(MAX_COLUMNS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int MEM_W      = 2 * CW + 1;
   localparam int PROD_W     = CW - 1 + INV_W;
   localparam int IDX_W      = PROD_W - FRAC_SHIFT;
   localparam int COLS_W     = $clog2(MAX_COLUMNS + 1);
   localparam int ROWS_W     = $clog2(MAX_ROWS + 1);
   localparam int GCC_W      = (COLS_W > GRID_COLS_W) ? COLS_W : GRID_COLS_W;
   localparam int GRC_W      = (ROWS_W > GRID_ROWS_W) ? ROWS_W : GRID_ROWS_W;
   localparam int CIC_W      = (IDX_W > COLS_W) ? IDX_W : COLS_W;
   localparam int RIC_W      = (IDX_W > ROWS_W) ? IDX_W : ROWS_W;
   localparam int AREA_CMP_W = (CW - 1 > AREA_W) ? CW - 1 : AREA_W;
   localparam int NC_W       = COL_W + 2;
   localparam int NR_W       = ROW_W + 2;

   // configuration registers
   logic [AREA_W-1:0]      area_width_ff, area_height_ff;
   logic [GAP_W-1:0]       gap_squared_ff;
   logic [INV_W-1:0]       inv_side_ff;
   logic [GRID_COLS_W-1:0] grid_cols_ff;
   logic [GRID_ROWS_W-1:0] grid_rows_ff;

   // sequencer state
   pdg_state_type          state_ff, state_in;
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;
   logic signed [CW-1:0]   x_ff, x_in, y_ff, y_in;
   logic [PROD_W-1:0]      colp_ff, colp_in, rowp_ff, rowp_in;
   logic                   area_bad_ff, area_bad_in;
   logic                   oob_ff, oob_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [1:0]             col_sel_ff, col_sel_in, row_sel_ff, row_sel_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [OUT_COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [OUT_ROW_W-1:0]   rsp_row_ff, rsp_row_in;

   // datapath nets
   logic [COLS_W-1:0]      cols_eff;
   logic [ROWS_W-1:0]      rows_eff;
   logic [IDX_W-1:0]       col_full, row_full;
   logic [NC_W-1:0]        nb_col;
   logic [NR_W-1:0]        nb_row;
   logic                   nb_live;
   logic                   rsp_free;

   // cell store and distance unit nets
   logic                   mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]      mem_wr_addr, mem_rd_addr;
   logic [MEM_W-1:0]       mem_wr_data, mem_rd_data;
   dist_ctrl_type          dist_ctrl;
   logic                   dist_conflict, dist_busy;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      cell_addr = ADDR_W'(r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(c);
   endfunction

   // register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_width_ff  <= AREA_WIDTH_RST;
         area_height_ff <= AREA_HEIGHT_RST;
         gap_squared_ff <= GAP_SQUARED_RST;
         inv_side_ff    <= INV_SIDE_RST;
         grid_cols_ff   <= GRID_COLS_RST;
         grid_rows_ff   <= GRID_ROWS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_AREA_WIDTH:  area_width_ff  <= csr_data[AREA_W-1:0];
            REG_AREA_HEIGHT: area_height_ff <= csr_data[AREA_W-1:0];
            REG_GAP_SQUARED: gap_squared_ff <= csr_data[GAP_W-1:0];
            REG_INV_SIDE:    inv_side_ff    <= csr_data[INV_W-1:0];
            REG_GRID_COLS:   grid_cols_ff   <= csr_data[GRID_COLS_W-1:0];
            REG_GRID_ROWS:   grid_rows_ff   <= csr_data[GRID_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // grid size in use, saturated at the store size
   assign cols_eff = (GCC_W'(grid_cols_ff) > GCC_W'(MAX_COLUMNS)) ?
                     COLS_W'(MAX_COLUMNS) : COLS_W'(grid_cols_ff);
   assign rows_eff = (GRC_W'(grid_rows_ff) > GRC_W'(MAX_ROWS)) ?
                     ROWS_W'(MAX_ROWS) : ROWS_W'(grid_rows_ff);

   // integer cell index from the scaled coordinates
   assign col_full = colp_ff[PROD_W-1:FRAC_SHIFT];
   assign row_full = rowp_ff[PROD_W-1:FRAC_SHIFT];

   // current neighbor; below zero wraps to all ones and fails the compare
   assign nb_col  = NC_W'(col_ff) + NC_W'(col_sel_ff) - NC_W'(1);
   assign nb_row  = NR_W'(row_ff) + NR_W'(row_sel_ff) - NR_W'(1);
   assign nb_live = (nb_col < NC_W'(cols_eff)) && (nb_row < NR_W'(rows_eff));

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // sequencer: next state, datapath loads, memory control
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      colp_in       = colp_ff;
      rowp_in       = rowp_ff;
      area_bad_in   = area_bad_ff;
      oob_in        = oob_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      col_sel_in    = col_sel_ff;
      row_sel_in    = row_sel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = clr_addr_ff;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = cell_addr(nb_row[ROW_W-1:0], nb_col[COL_W-1:0]);
      dist_ctrl     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in     = req_tdata[CW-1:0];
               y_in     = req_tdata[2*CW-1:CW];
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            // area test and Q11.4 x Q8.16 scaling
            colp_in     = PROD_W'(x_ff[CW-2:0]) * PROD_W'(inv_side_ff);
            rowp_in     = PROD_W'(y_ff[CW-2:0]) * PROD_W'(inv_side_ff);
            area_bad_in = x_ff[CW-1] || y_ff[CW-1] ||
                          (AREA_CMP_W'(x_ff[CW-2:0]) > AREA_CMP_W'(area_width_ff)) ||
                          (AREA_CMP_W'(y_ff[CW-2:0]) > AREA_CMP_W'(area_height_ff));
            state_in    = ST_BOUND;
         end
         ST_BOUND: begin
            oob_in = area_bad_ff ||
                     (CIC_W'(col_full) >= CIC_W'(cols_eff)) ||
                     (RIC_W'(row_full) >= RIC_W'(rows_eff));
            col_in     = col_full[COL_W-1:0];
            row_in     = row_full[ROW_W-1:0];
            col_sel_in = 2'd0;
            row_sel_in = 2'd0;
            dist_ctrl.clear = 1'b1;
            state_in   = oob_in ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            // one neighbor read a cycle, rows outer, columns inner
            mem_rd_en       = nb_live;
            dist_ctrl.probe = nb_live;
            if (col_sel_ff == 2'd2) begin
               col_sel_in = 2'd0;
               row_sel_in = row_sel_ff + 2'd1;
               if (row_sel_ff == 2'd2) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               col_sel_in = col_sel_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            if (!dist_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // result out, and write-back on accept, once the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (oob_ff) begin
                  rsp_status_in = STATUS_OUT_OF_BOUNDS;
                  rsp_col_in    = '0;
                  rsp_row_in    = '0;
               end else begin
                  rsp_col_in = OUT_COL_W'(col_ff);
                  rsp_row_in = OUT_ROW_W'(row_ff);
                  if (dist_conflict) begin
                     rsp_status_in = STATUS_CONFLICT;
                  end else begin
                     rsp_status_in = STATUS_ACCEPT;
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = cell_addr(row_ff, col_ff);
                     mem_wr_data   = {1'b1, y_ff, x_ff};
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      colp_ff       <= colp_in;
      rowp_ff       <= rowp_in;
      area_bad_ff   <= area_bad_in;
      oob_ff        <= oob_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      col_sel_ff    <= col_sel_in;
      row_sel_ff    <= row_sel_in;
      rsp_status_ff <= rsp_status_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_row_ff, rsp_col_ff, rsp_status_ff};

   // cell store; reads and the write-back never share a cycle
   pdg_cell_mem #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W),
      .DATA_W (MEM_W)
   ) u_cell_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pdg_dist_unit #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dist_unit (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (dist_ctrl),
      .cand_x      (x_ff),
      .cand_y      (y_ff),
      .cell_valid  (mem_rd_data[MEM_W-1]),
      .cell_x      (mem_rd_data[CW-1:0]),
      .cell_y      (mem_rd_data[2*CW-1:CW]),
      .gap_squared (gap_squared_ff),
      .conflict    (dist_conflict),
      .busy        (dist_busy)
   );

`ifndef NO_ASSERTIONS
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("candidate accepted during clearing pass");

   a_no_write_during_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !mem_wr_en)
      else $error("cell store written while neighbors are read");

   a_finish_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !dist_busy)
      else $error("result decided with distance checks in flight");

   a_oob_zero_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_OUT_OF_BOUNDS) |->
      (rsp_col_ff == '0 && rsp_row_ff == '0))
      else $error("out of bounds result carries a cell index");
`endif

endmodule
